@@ rtl/core/pohp_pkg.sv @@
// shared types and constants for the pack object header parser
// no dependencies; imported by pohp_step and pack_object_header_parser_unit

package pohp_pkg;

   // number of base-hash bytes that follow a ref-delta header
   localparam int HASH_BYTES = 20;

   // object type codes that change what follows the size varint
   localparam logic [2:0] TYPE_OFS_DELTA = 3'd6;
   localparam logic [2:0] TYPE_REF_DELTA = 3'd7;

   // header byte fields
   localparam logic [7:0] BYTE_MORE  = 8'h80;
   localparam logic [6:0] GROUP_MASK = 7'h7f;

   // size group position after the first byte and its clamp value
   localparam logic [6:0] SHIFT_FIRST = 7'd4;
   localparam logic [6:0] SHIFT_STEP  = 7'd7;
   localparam logic [6:0] SHIFT_MAX   = 7'd64;
   // marks the first offset byte while in the offset phase
   localparam logic [6:0] SHIFT_OFS_START = 7'd0;

   // result bus packing
   localparam int RSP_FIELDS_W = 146;
   localparam int RSP_DATA_W   = 152;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   typedef enum logic [1:0] {
      PH_FIRST = 2'd0,
      PH_SIZE  = 2'd1,
      PH_OFS   = 2'd2,
      PH_HASH  = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  obj_type;
      logic [63:0] size_acc;
      logic [6:0]  shift_amount;
      logic [63:0] offset_acc;
      logic [4:0]  hash_count;
      logic        overflow;
   } pohp_state_type;

   typedef struct packed {
      logic        header_done;
      logic [2:0]  obj_type;
      logic [63:0] obj_size;
      logic [63:0] delta_offset;
      logic        hash_valid;
      logic [7:0]  hash_value;
      logic [4:0]  hash_position;
      logic        overflow;
      logic        in_header;
   } pohp_result_type;

   localparam pohp_state_type STATE_RESET = '{
      phase:        PH_FIRST,
      obj_type:     3'd0,
      size_acc:     64'd0,
      shift_amount: SHIFT_FIRST,
      offset_acc:   64'd0,
      hash_count:   5'd0,
      overflow:     1'b0
   };

endpackage

@@ rtl/core/pohp_step.sv @@
// decode of one header byte against the current parser state
// depends on pohp_pkg; combinational, used by pack_object_header_parser_unit

module pohp_step
   import pohp_pkg::*;
(
   input  pohp_state_type  cur_state,
   input  logic [7:0]      data_byte,
   input  logic            restart,
   output pohp_state_type  nxt_state,
   output pohp_result_type result
);

   phase_type   phase_eff;
   logic [6:0]  group;
   logic        more;
   logic [70:0] group_shifted;
   logic [6:0]  shift_sum;
   logic [64:0] ofs_plus;
   logic [5:0]  hash_next;
   logic        done;
   logic        hvalid;

   // restart abandons any partial header
   assign phase_eff = restart ? PH_FIRST : cur_state.phase;
   assign group     = data_byte[6:0] & GROUP_MASK;
   assign more      = (data_byte & BYTE_MORE) != 8'd0;

   // size group placed at its bit position; bits past 63 mean overflow
   assign group_shifted = {64'd0, group} << cur_state.shift_amount[5:0];
   assign shift_sum     = cur_state.shift_amount + SHIFT_STEP;
   assign ofs_plus      = {1'b0, cur_state.offset_acc} + 65'd1;
   assign hash_next     = {1'b0, cur_state.hash_count} + 6'd1;

   // next state and done flag
   always_comb begin
      nxt_state = cur_state;
      done      = 1'b0;
      hvalid    = 1'b0;
      case (phase_eff)
         PH_FIRST: begin
            nxt_state.obj_type     = data_byte[6:4];
            nxt_state.size_acc     = {60'd0, data_byte[3:0]};
            nxt_state.shift_amount = SHIFT_FIRST;
            nxt_state.offset_acc   = 64'd0;
            nxt_state.hash_count   = 5'd0;
            nxt_state.overflow     = 1'b0;
            if (more) begin
               nxt_state.phase = PH_SIZE;
            end else if (data_byte[6:4] == TYPE_OFS_DELTA) begin
               nxt_state.phase        = PH_OFS;
               nxt_state.shift_amount = SHIFT_OFS_START;
            end else if (data_byte[6:4] == TYPE_REF_DELTA) begin
               nxt_state.phase = PH_HASH;
            end else begin
               nxt_state.phase = PH_FIRST;
               done            = 1'b1;
            end
         end
         PH_SIZE: begin
            // add seven size bits, clamp the position at 64
            if (cur_state.shift_amount >= SHIFT_MAX) begin
               if (group != 7'd0) begin
                  nxt_state.overflow = 1'b1;
               end
            end else begin
               if (group_shifted[70:64] != 7'd0) begin
                  nxt_state.overflow = 1'b1;
               end
               nxt_state.size_acc     = cur_state.size_acc | group_shifted[63:0];
               nxt_state.shift_amount = (shift_sum > SHIFT_MAX) ? SHIFT_MAX : shift_sum;
            end
            if (!more) begin
               if (cur_state.obj_type == TYPE_OFS_DELTA) begin
                  nxt_state.phase        = PH_OFS;
                  nxt_state.shift_amount = SHIFT_OFS_START;
               end else if (cur_state.obj_type == TYPE_REF_DELTA) begin
                  nxt_state.phase      = PH_HASH;
                  nxt_state.hash_count = 5'd0;
               end else begin
                  nxt_state.phase = PH_FIRST;
                  done            = 1'b1;
               end
            end
         end
         PH_OFS: begin
            // offset varint: add one before each seven-bit shift
            if (cur_state.shift_amount == SHIFT_OFS_START) begin
               nxt_state.offset_acc   = {57'd0, group};
               nxt_state.shift_amount = SHIFT_STEP;
            end else begin
               if (ofs_plus[63:0] == 64'd0 || ofs_plus[63:57] != 7'd0) begin
                  nxt_state.overflow = 1'b1;
               end
               nxt_state.offset_acc = {ofs_plus[56:0], group};
            end
            if (!more) begin
               nxt_state.phase = PH_FIRST;
               done            = 1'b1;
            end
         end
         PH_HASH: begin
            hvalid = 1'b1;
            if (hash_next >= 6'(HASH_BYTES)) begin
               nxt_state.phase      = PH_FIRST;
               nxt_state.hash_count = 5'd0;
               done                 = 1'b1;
            end else begin
               nxt_state.hash_count = hash_next[4:0];
            end
         end
         default: begin
            nxt_state.phase = PH_FIRST;
         end
      endcase
   end

   // result fields from the updated state; the hash byte index comes from the current state
   always_comb begin
      result.header_done   = done;
      result.obj_type      = nxt_state.obj_type;
      result.obj_size      = nxt_state.size_acc;
      result.delta_offset  = (nxt_state.obj_type == TYPE_OFS_DELTA) ?
                             nxt_state.offset_acc : 64'd0;
      result.hash_valid    = hvalid;
      result.hash_value    = hvalid ? data_byte : 8'd0;
      result.hash_position = hvalid ? cur_state.hash_count : 5'd0;
      result.overflow      = nxt_state.overflow;
      result.in_header     = (nxt_state.phase != PH_FIRST);
   end

endmodule

@@ rtl/core/pack_object_header_parser_unit.sv @@
// top level of the pack object header parser: state and result registers
// depends on pohp_pkg and pohp_step
//
//  channel  direction  tdata / tuser / tlast
//  req      in         tdata: data_byte; tuser: restart
//  rsp      out        tdata: type, size, offset, hash byte, index, overflow,
//                      in_header; tuser: hash_valid; tlast: header_done
//
// one byte is taken per cycle unless a held result stalls; each gives one result
// the rate is set by the single state update loop through pohp_step
// synchronous reset puts the parser in the expect-first-byte phase
// the result register holds under rsp_tready low; req_tready stays high
// whenever the held result is being taken in the same cycle

module pack_object_header_parser_unit
   import pohp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // data_byte
   input  logic                  req_tuser,  // restart
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // obj_type, obj_size, delta_offset, hash_value, hash_position, overflow,
   // in_header, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,  // hash_valid
   output logic                  rsp_tlast   // header_done
);

   pohp_state_type  state_ff, state_in;
   pohp_result_type step_result;
   pohp_result_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_xfer;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   pohp_step u_step (
      .cur_state (state_ff),
      .data_byte (req_tdata),
      .restart   (req_tuser),
      .nxt_state (state_in),
      .result    (step_result)
   );

   // parser state advances on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
         rsp_in       = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // result packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.header_done;
   assign rsp_tuser  = rsp_ff.hash_valid;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ff.in_header, rsp_ff.overflow,
                        rsp_ff.hash_position, rsp_ff.hash_value,
                        rsp_ff.delta_offset, rsp_ff.obj_size, rsp_ff.obj_type};

   // checks
   a_xfer_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid_ff)
      else $error("input transfer without a following result");

   a_done_ends_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.header_done |-> !rsp_ff.in_header)
      else $error("finished header still marked in progress");

   a_hash_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.hash_valid |-> rsp_ff.hash_position < 5'(HASH_BYTES - 1)
                                            || rsp_ff.hash_position == 5'(HASH_BYTES - 1))
      else $error("hash byte index past the hash length");

   a_offset_only_ofs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.delta_offset != 64'd0 |-> rsp_ff.obj_type == TYPE_OFS_DELTA)
      else $error("delta offset on a non offset-delta object");

   a_hash_only_ref: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.hash_valid |-> rsp_ff.obj_type == TYPE_REF_DELTA)
      else $error("hash byte on a non ref-delta object");

endmodule
